@@ hw/rtl/gmk_pkg.sv @@
// galvo mirror kinematics package: widths, stage record, cordic angle table
// used by galvo_mirror_kinematics_top; no dependencies
package gmk_pkg;

  localparam int CW = 60;          // cordic x/y width
  localparam int ZW = 34;          // cordic angle width
  localparam int VEC_SHIFT = 24;
  localparam int NTAB = 32;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] ROT_X0 = 60'sd1073741824;
  localparam logic [31:0] SAT_POS = 32'h7fff_ffff;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  localparam logic [0:0] REG_MIRROR_SPACING = 1'b0;
  localparam logic [0:0] REG_SCAN_HEIGHT    = 1'b1;

  localparam logic [0:0] OP_POS_TO_ANG = 1'b0;
  localparam logic [0:0] OP_ANG_TO_POS = 1'b1;

  localparam logic [30:0] ATAN_TAB [NTAB] = '{
    31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159,
    31'd67021687, 31'd33543516, 31'd16775851, 31'd8388437,
    31'd4194283, 31'd2097149, 31'd1048576, 31'd524288,
    31'd262144, 31'd131072, 31'd65536, 31'd32768,
    31'd16384, 31'd8192, 31'd4096, 31'd2048,
    31'd1024, 31'd512, 31'd256, 31'd128,
    31'd64, 31'd32, 31'd16, 31'd8,
    31'd4, 31'd2, 31'd1, 31'd0
  };

  typedef struct packed {
    logic [0:0]             op;
    logic                   flg;
    logic [31:0]            v1;
    logic [31:0]            v2;
    logic signed [CW-1:0]   x1;
    logic signed [CW-1:0]   y1;
    logic signed [ZW-1:0]   z1;
    logic signed [CW-1:0]   x2;
    logic signed [CW-1:0]   y2;
    logic signed [ZW-1:0]   z2;
    logic [30:0]            ca;
    logic [30:0]            sam;
    logic                   san;
    logic [30:0]            cb;
    logic [30:0]            sbm;
    logic                   sbn;
    logic [31:0]            ym;
    logic [63:0]            pa;
    logic [63:0]            pb;
    logic [63:0]            rad;
    logic [63:0]            root;
    logic [61:0]            py;
    logic [61:0]            p1;
    logic [31:0]            rem1;
    logic [61:0]            q1;
    logic [31:0]            remy;
    logic [31:0]            qy;
    logic                   ovy;
    logic [62:0]            rr;
    logic [62:0]            plo;
    logic [61:0]            phi;
    logic [93:0]            px;
    logic [31:0]            remx;
    logic [31:0]            qx;
    logic                   ovx;
    logic [31:0]            res1;
    logic [31:0]            res2;
  } stage_t;

endpackage

@@ hw/rtl/galvo_mirror_kinematics_top.sv @@
// galvo mirror kinematics: position <-> mirror angle conversion, fully pipelined
// depends on gmk_pkg
//
// usage:
//   s_axis carries one request per beat: tdata = {second_value, first_value},
//   tuser = op (0 position to angles, 1 angles to position).
//   m_axis returns one result per request in order: tdata = {second_result,
//   first_result}, tuser = saturated.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write mirror_spacing (0) and scan_height (1);
//   write only while no request is in flight.
// stages: cordic rotation, 32-step square root, 62-step and 32-step restoring
//   divisions (the first alongside cordic vectoring), each one bit per stage.
// throughput: one request per cycle while the pipeline is not stalled.
// reset: all valid bits clear, config registers take their reset values.
// stall: when the output holds a result and m_axis_tready is low the whole
//   pipeline holds and s_axis_tready drops; nothing is lost or repeated.
module galvo_mirror_kinematics_top #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // first_value, second_value
  input  logic [0:0]  s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // first_result, second_result
  output logic [0:0]  m_axis_tuser,   // saturated
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [30:0] cfg_wdata_i
);

  localparam int N      = CORDIC_STEPS;
  localparam int S_FIX  = N + 1;
  localparam int S_SQ   = N + 2;
  localparam int S_ADD  = N + 3;
  localparam int S_SQR  = N + 4;
  localparam int S_PREP = N + 36;
  localparam int S_DIV  = N + 37;
  localparam int S_RR   = N + 99;
  localparam int S_M1   = N + 100;
  localparam int S_M2   = N + 101;
  localparam int S_CMB  = N + 102;
  localparam int S_CHK  = N + 103;
  localparam int S_XDIV = N + 104;
  localparam int S_OUT  = N + 136;
  localparam int NST    = N + 137;

  logic [22:0] spacing_q;
  logic [30:0] height_q;

  gmk_pkg::stage_t st_q [NST];
  gmk_pkg::stage_t st_d [NST];
  logic [NST-1:0]  vld_q;
  logic            adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= 23'd491520;
      height_q  <= 31'd36687551;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gmk_pkg::REG_MIRROR_SPACING: spacing_q <= cfg_wdata_i[22:0];
        gmk_pkg::REG_SCAN_HEIGHT:    height_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign adv           = !vld_q[NST-1] || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
    end
  end

  for (genvar s = 0; s < NST; s++) begin : g_st
    if (s == 0) begin : g_in
      always_comb begin
        logic signed [gmk_pkg::ZW-1:0] a1, a2;
        logic c1, c2;
        a1 = gmk_pkg::ZW'($signed(s_axis_tdata[31:0]));
        a2 = gmk_pkg::ZW'($signed(s_axis_tdata[63:32]));
        st_d[s]    = '0;
        st_d[s].op = s_axis_tuser;
        st_d[s].v1 = s_axis_tdata[31:0];
        st_d[s].v2 = s_axis_tdata[63:32];
        c1 = (a1 > gmk_pkg::HALF_PI_Q30) || (a1 < -gmk_pkg::HALF_PI_Q30);
        c2 = (a2 > gmk_pkg::HALF_PI_Q30) || (a2 < -gmk_pkg::HALF_PI_Q30);
        st_d[s].z1 = (a1 > gmk_pkg::HALF_PI_Q30) ? gmk_pkg::HALF_PI_Q30 :
                     (a1 < -gmk_pkg::HALF_PI_Q30) ? -gmk_pkg::HALF_PI_Q30 : a1;
        st_d[s].z2 = (a2 > gmk_pkg::HALF_PI_Q30) ? gmk_pkg::HALF_PI_Q30 :
                     (a2 < -gmk_pkg::HALF_PI_Q30) ? -gmk_pkg::HALF_PI_Q30 : a2;
        st_d[s].x1  = gmk_pkg::ROT_X0;
        st_d[s].x2  = gmk_pkg::ROT_X0;
        st_d[s].flg = (s_axis_tuser == gmk_pkg::OP_ANG_TO_POS) && (c1 || c2);
      end
    end else if (s <= N) begin : g_rot
      localparam int I = s - 1;
      localparam logic signed [gmk_pkg::ZW-1:0] TA =
        gmk_pkg::ZW'($signed({1'b0, gmk_pkg::ATAN_TAB[I]}));
      always_comb begin
        gmk_pkg::stage_t p;
        p       = st_q[s-1];
        st_d[s] = p;
        if (!p.z1[gmk_pkg::ZW-1]) begin
          st_d[s].x1 = p.x1 - (p.y1 >>> I);
          st_d[s].y1 = p.y1 + (p.x1 >>> I);
          st_d[s].z1 = p.z1 - TA;
        end else begin
          st_d[s].x1 = p.x1 + (p.y1 >>> I);
          st_d[s].y1 = p.y1 - (p.x1 >>> I);
          st_d[s].z1 = p.z1 + TA;
        end
        if (!p.z2[gmk_pkg::ZW-1]) begin
          st_d[s].x2 = p.x2 - (p.y2 >>> I);
          st_d[s].y2 = p.y2 + (p.x2 >>> I);
          st_d[s].z2 = p.z2 - TA;
        end else begin
          st_d[s].x2 = p.x2 + (p.y2 >>> I);
          st_d[s].y2 = p.y2 - (p.x2 >>> I);
          st_d[s].z2 = p.z2 + TA;
        end
      end
    end else if (s == S_FIX) begin : g_fix
      always_comb begin
        gmk_pkg::stage_t p;
        logic signed [gmk_pkg::CW-1:0] ny1, ny2;
        p       = st_q[s-1];
        ny1     = -p.y1;
        ny2     = -p.y2;
        st_d[s] = p;
        st_d[s].ca  = (p.x1 <= 0) ? 31'd1 : p.x1[30:0];
        st_d[s].cb  = (p.x2 <= 0) ? 31'd1 : p.x2[30:0];
        st_d[s].san = p.y1[gmk_pkg::CW-1];
        st_d[s].sbn = p.y2[gmk_pkg::CW-1];
        st_d[s].sam = p.y1[gmk_pkg::CW-1] ? ny1[30:0] : p.y1[30:0];
        st_d[s].sbm = p.y2[gmk_pkg::CW-1] ? ny2[30:0] : p.y2[30:0];
        st_d[s].ym  = p.v2[31] ? (32'd0 - p.v2) : p.v2;
      end
    end else if (s == S_SQ) begin : g_sq
      always_comb begin
        gmk_pkg::stage_t p;
        logic [31:0] ma, mb;
        p       = st_q[s-1];
        st_d[s] = p;
        ma = (p.op == gmk_pkg::OP_ANG_TO_POS) ? {1'b0, p.cb} : {1'b0, height_q};
        mb = (p.op == gmk_pkg::OP_ANG_TO_POS) ? {1'b0, p.sbm} : p.ym;
        st_d[s].pa = 64'(ma) * 64'(ma);
        st_d[s].pb = 64'(mb) * 64'(mb);
      end
    end else if (s == S_ADD) begin : g_add
      always_comb begin
        gmk_pkg::stage_t p;
        p       = st_q[s-1];
        st_d[s] = p;
        st_d[s].rad  = p.pa + p.pb;
        st_d[s].root = '0;
        st_d[s].py   = 62'(height_q) * 62'(p.sbm);
      end
    end else if (s < S_PREP) begin : g_sqrt
      localparam int K = s - S_SQR;
      localparam logic [63:0] B = 64'd1 << (62 - 2 * K);
      always_comb begin
        gmk_pkg::stage_t p;
        logic [63:0] t;
        p       = st_q[s-1];
        t       = p.root + B;
        st_d[s] = p;
        if (p.rad >= t) begin
          st_d[s].rad  = p.rad - t;
          st_d[s].root = (p.root >> 1) + B;
        end else begin
          st_d[s].root = p.root >> 1;
        end
      end
    end else if (s == S_PREP) begin : g_prep
      always_comb begin
        gmk_pkg::stage_t p;
        logic [62:0] prod;
        p       = st_q[s-1];
        prod    = 63'(height_q) * 63'(p.root[31:0]);
        st_d[s] = p;
        st_d[s].x1 = (gmk_pkg::CW'(p.root[32:0]) + gmk_pkg::CW'(spacing_q))
                     <<< gmk_pkg::VEC_SHIFT;
        st_d[s].y1 = gmk_pkg::CW'($signed(p.v1)) <<< gmk_pkg::VEC_SHIFT;
        st_d[s].x2 = gmk_pkg::CW'(height_q) <<< gmk_pkg::VEC_SHIFT;
        st_d[s].y2 = gmk_pkg::CW'($signed(p.v2)) <<< gmk_pkg::VEC_SHIFT;
        st_d[s].z1 = '0;
        st_d[s].z2 = '0;
        st_d[s].p1   = prod[61:0];
        st_d[s].rem1 = '0;
        st_d[s].q1   = '0;
        st_d[s].remy = {2'b00, p.py[61:32]};
        st_d[s].qy   = '0;
        st_d[s].ovy  = {2'b00, p.py[61:32]} >= {1'b0, p.cb};
      end
    end else if (s < S_RR) begin : g_div
      localparam int K  = s - S_DIV;
      localparam int KY = (K < 32) ? 31 - K : 0;
      localparam int KV = (K < N) ? K : 0;
      localparam logic signed [gmk_pkg::ZW-1:0] TA =
        gmk_pkg::ZW'($signed({1'b0, gmk_pkg::ATAN_TAB[KV]}));
      always_comb begin
        gmk_pkg::stage_t p;
        logic [31:0] r1, ry;
        p       = st_q[s-1];
        st_d[s] = p;
        r1 = {p.rem1[30:0], p.p1[61-K]};
        if (r1 >= {1'b0, p.cb}) begin
          st_d[s].rem1      = r1 - {1'b0, p.cb};
          st_d[s].q1[61-K]  = 1'b1;
        end else begin
          st_d[s].rem1 = r1;
        end
        ry = {p.remy[30:0], p.py[KY]};
        if (K < 32) begin
          if (ry >= {1'b0, p.cb}) begin
            st_d[s].remy     = ry - {1'b0, p.cb};
            st_d[s].qy[KY]   = 1'b1;
          end else begin
            st_d[s].remy = ry;
          end
        end
        if (K < N) begin
          if (!p.y1[gmk_pkg::CW-1]) begin
            st_d[s].x1 = p.x1 + (p.y1 >>> KV);
            st_d[s].y1 = p.y1 - (p.x1 >>> KV);
            st_d[s].z1 = p.z1 + TA;
          end else begin
            st_d[s].x1 = p.x1 - (p.y1 >>> KV);
            st_d[s].y1 = p.y1 + (p.x1 >>> KV);
            st_d[s].z1 = p.z1 - TA;
          end
          if (!p.y2[gmk_pkg::CW-1]) begin
            st_d[s].x2 = p.x2 + (p.y2 >>> KV);
            st_d[s].y2 = p.y2 - (p.x2 >>> KV);
            st_d[s].z2 = p.z2 + TA;
          end else begin
            st_d[s].x2 = p.x2 - (p.y2 >>> KV);
            st_d[s].y2 = p.y2 + (p.x2 >>> KV);
            st_d[s].z2 = p.z2 - TA;
          end
        end
      end
    end else if (s == S_RR) begin : g_rr
      always_comb begin
        st_d[s]    = st_q[s-1];
        st_d[s].rr = 63'(st_q[s-1].q1) + 63'(spacing_q);
      end
    end else if (s == S_M1) begin : g_m1
      always_comb begin
        st_d[s]     = st_q[s-1];
        st_d[s].plo = 63'(st_q[s-1].rr[31:0]) * 63'(st_q[s-1].sam);
      end
    end else if (s == S_M2) begin : g_m2
      always_comb begin
        st_d[s]     = st_q[s-1];
        st_d[s].phi = 62'(st_q[s-1].rr[62:32]) * 62'(st_q[s-1].sam);
      end
    end else if (s == S_CMB) begin : g_cmb
      always_comb begin
        st_d[s]    = st_q[s-1];
        st_d[s].px = (94'(st_q[s-1].phi) << 32) + 94'(st_q[s-1].plo);
      end
    end else if (s == S_CHK) begin : g_chk
      always_comb begin
        st_d[s]      = st_q[s-1];
        st_d[s].ovx  = st_q[s-1].px[93:32] >= 62'(st_q[s-1].ca);
        st_d[s].remx = st_q[s-1].px[63:32];
        st_d[s].qx   = '0;
      end
    end else if (s < S_OUT) begin : g_xdiv
      localparam int K = s - S_XDIV;
      always_comb begin
        gmk_pkg::stage_t p;
        logic [31:0] r;
        p       = st_q[s-1];
        st_d[s] = p;
        r = {p.remx[30:0], p.px[31-K]};
        if (r >= {1'b0, p.ca}) begin
          st_d[s].remx      = r - {1'b0, p.ca};
          st_d[s].qx[31-K]  = 1'b1;
        end else begin
          st_d[s].remx = r;
        end
      end
    end else begin : g_out
      always_comb begin
        gmk_pkg::stage_t p;
        p       = st_q[s-1];
        st_d[s] = p;
        if (p.op == gmk_pkg::OP_POS_TO_ANG) begin
          st_d[s].res1 = p.z1[31:0];
          st_d[s].res2 = p.z2[31:0];
        end else begin
          if (!p.san) begin
            if (p.ovx || p.qx[31]) begin
              st_d[s].res1 = gmk_pkg::SAT_POS;
              st_d[s].flg  = 1'b1;
            end else begin
              st_d[s].res1 = p.qx;
            end
          end else if (p.ovx || (p.qx > gmk_pkg::SAT_NEG)) begin
            st_d[s].res1 = gmk_pkg::SAT_NEG;
            st_d[s].flg  = 1'b1;
          end else begin
            st_d[s].res1 = 32'd0 - p.qx;
          end
          if (!p.sbn) begin
            if (p.ovy || p.qy[31]) begin
              st_d[s].res2 = gmk_pkg::SAT_POS;
              st_d[s].flg  = 1'b1;
            end else begin
              st_d[s].res2 = p.qy;
            end
          end else if (p.ovy || (p.qy > gmk_pkg::SAT_NEG)) begin
            st_d[s].res2 = gmk_pkg::SAT_NEG;
            st_d[s].flg  = 1'b1;
          end else begin
            st_d[s].res2 = 32'd0 - p.qy;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  assign m_axis_tvalid = vld_q[NST-1];
  assign m_axis_tdata  = {st_q[NST-1].res2, st_q[NST-1].res1};
  assign m_axis_tuser  = st_q[NST-1].flg;

  a_pos_no_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NST-1] && (st_q[NST-1].op == gmk_pkg::OP_POS_TO_ANG) |-> !st_q[NST-1].flg)
    else $error("position request flagged saturated");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && adv |=> vld_q[0])
    else $error("accepted request not captured");

endmodule
